// ===== design/binomial_coefficient_unit_core_macros.svh =====
// Assertion macros for the binomial coefficient unit.
// Used by the top level; relies on clk_i and rst_ni in the including scope.
`ifndef BINOMIAL_COEFFICIENT_UNIT_CORE_MACROS_SVH
`define BINOMIAL_COEFFICIENT_UNIT_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset
`define BCU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bcu assertion failed");

// Next-cycle implication, checked out of reset
`define BCU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bcu assertion failed");

`endif

// ===== design/bcu_pkg.sv =====
// Shared types and constants for the binomial coefficient unit.
// No dependencies.
`default_nettype none
package bcu_pkg;

  localparam int unsigned FIELD_W   = 64;
  localparam int unsigned DEF_WIDTH = 64;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_LOOP, ST_DIVM_RUN, ST_DIVM_END, ST_DIVR_RUN,
    ST_DIVR_END, ST_MUL_GO, ST_MUL_RUN, ST_MUL_END, ST_DIVP_RUN,
    ST_DIVP_END, ST_OUT
  } state_e;

  typedef enum logic [3:0] {
    CMD_NOP, CMD_LOAD, CMD_SETUP, CMD_DIV_M, CMD_DIV_R, CMD_DIV_P, CMD_MUL,
    CMD_DIV_STEP, CMD_MUL_STEP, CMD_TAKE_M, CMD_TAKE_R, CMD_TAKE_P_NEXT,
    CMD_TAKE_Q_NEXT, CMD_FIN_ZERO, CMD_FIN_OVF, CMD_FIN_R
  } cmd_e;

  typedef struct packed {
    logic cnt_zero;  // iteration count exhausted
    logic rem_zero;  // remainder / product high half is zero
    logic k_gt_n;
    logic d_gt_k;
    logic early;     // division already done before the multiply
  } stat_t;

endpackage
`default_nettype wire

// ===== design/bcu_datapath.sv =====
// Datapath: operand registers and a shared bit-serial divide/multiply unit.
// Depends on bcu_pkg.
`default_nettype none
module bcu_datapath #(
  parameter int unsigned WIDTH = bcu_pkg::DEF_WIDTH
) (
  input  wire logic                       clk_i,
  input  wire bcu_pkg::cmd_e              cmd_i,
  input  wire logic [bcu_pkg::FIELD_W-1:0] n_value_i,
  input  wire logic [bcu_pkg::FIELD_W-1:0] k_value_i,
  output bcu_pkg::stat_t                  stat_o,
  output logic [WIDTH-1:0]                coef_o,
  output logic                            ovf_o
);
  import bcu_pkg::*;

  localparam int unsigned CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] n_q, k_q, r_q, m_q, d_q, quo_q, coef_q;
  logic [WIDTH:0]   rem_q;
  logic [CW-1:0]    cnt_q;
  logic             early_q, ovf_q;

  logic [WIDTH-1:0] m_next, nk;
  logic [WIDTH:0]   div_tmp, div_diff, mul_sum;
  logic             div_ge;

  // Falling factor and complement of k
  assign m_next = n_q - d_q + WIDTH'(1);
  assign nk     = n_q - k_q;

  // One restoring division step and one shift-add multiply step
  always_comb begin
    div_tmp  = {rem_q[WIDTH-1:0], quo_q[WIDTH-1]};
    div_ge   = (div_tmp >= {1'b0, d_q});
    div_diff = div_tmp - {1'b0, d_q};
    mul_sum  = {1'b0, rem_q[WIDTH-1:0]} + (quo_q[0] ? {1'b0, r_q} : '0);
  end

  // Execute controller commands
  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      CMD_LOAD: begin
        n_q <= n_value_i[WIDTH-1:0];
        k_q <= k_value_i[WIDTH-1:0];
      end
      CMD_SETUP: begin
        if (nk < k_q) k_q <= nk;
        r_q <= WIDTH'(1);
        d_q <= WIDTH'(1);
      end
      CMD_DIV_M: begin
        m_q     <= m_next;
        quo_q   <= m_next;
        rem_q   <= '0;
        cnt_q   <= CW'(WIDTH);
        early_q <= 1'b0;
      end
      CMD_DIV_R: begin
        quo_q <= r_q;
        rem_q <= '0;
        cnt_q <= CW'(WIDTH);
      end
      CMD_DIV_P: begin
        rem_q <= '0;
        cnt_q <= CW'(WIDTH);
      end
      CMD_MUL: begin
        quo_q <= m_q;
        rem_q <= '0;
        cnt_q <= CW'(WIDTH);
      end
      CMD_DIV_STEP: begin
        rem_q <= div_ge ? div_diff : div_tmp;
        quo_q <= {quo_q[WIDTH-2:0], div_ge};
        cnt_q <= cnt_q - CW'(1);
      end
      CMD_MUL_STEP: begin
        rem_q <= {1'b0, mul_sum[WIDTH:1]};
        quo_q <= {mul_sum[0], quo_q[WIDTH-1:1]};
        cnt_q <= cnt_q - CW'(1);
      end
      CMD_TAKE_M: begin
        m_q     <= quo_q;
        early_q <= 1'b1;
      end
      CMD_TAKE_R: begin
        r_q     <= quo_q;
        early_q <= 1'b1;
      end
      CMD_TAKE_P_NEXT, CMD_TAKE_Q_NEXT: begin
        r_q <= quo_q;
        d_q <= d_q + WIDTH'(1);
      end
      CMD_FIN_ZERO: begin
        coef_q <= '0;
        ovf_q  <= 1'b0;
      end
      CMD_FIN_OVF: begin
        coef_q <= '0;
        ovf_q  <= 1'b1;
      end
      CMD_FIN_R: begin
        coef_q <= r_q;
        ovf_q  <= 1'b0;
      end
      default: ;
    endcase
  end

  assign stat_o = '{cnt_zero: (cnt_q == '0), rem_zero: (rem_q == '0),
                    k_gt_n: (k_q > n_q), d_gt_k: (d_q > k_q), early: early_q};
  assign coef_o = coef_q;
  assign ovf_o  = ovf_q;
endmodule
`default_nettype wire

// ===== design/bcu_ctrl.sv =====
// Controller state machine sequencing the datapath for one item.
// Depends on bcu_pkg.
`default_nettype none
module bcu_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire bcu_pkg::stat_t stat_i,
  output bcu_pkg::cmd_e       cmd_o
);
  import bcu_pkg::*;

  state_e state_q, state_d;

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = ST_CHECK;
      ST_CHECK:    state_d = stat_i.k_gt_n ? ST_OUT : ST_LOOP;
      ST_LOOP:     state_d = stat_i.d_gt_k ? ST_OUT : ST_DIVM_RUN;
      ST_DIVM_RUN: if (stat_i.cnt_zero) state_d = ST_DIVM_END;
      ST_DIVM_END: state_d = stat_i.rem_zero ? ST_MUL_GO : ST_DIVR_RUN;
      ST_DIVR_RUN: if (stat_i.cnt_zero) state_d = ST_DIVR_END;
      ST_DIVR_END: state_d = ST_MUL_GO;
      ST_MUL_GO:   state_d = ST_MUL_RUN;
      ST_MUL_RUN:  if (stat_i.cnt_zero) state_d = ST_MUL_END;
      ST_MUL_END: begin
        priority if (!stat_i.rem_zero) state_d = ST_OUT;
        else if (stat_i.early)         state_d = ST_LOOP;
        else                           state_d = ST_DIVP_RUN;
      end
      ST_DIVP_RUN: if (stat_i.cnt_zero) state_d = ST_DIVP_END;
      ST_DIVP_END: state_d = ST_LOOP;
      ST_OUT:      if (out_ready_i) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Commands and handshake outputs
  always_comb begin
    cmd_o       = CMD_NOP;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o = CMD_LOAD;
      end
      ST_CHECK:    cmd_o = stat_i.k_gt_n ? CMD_FIN_ZERO : CMD_SETUP;
      ST_LOOP:     cmd_o = stat_i.d_gt_k ? CMD_FIN_R : CMD_DIV_M;
      ST_DIVM_RUN, ST_DIVR_RUN, ST_DIVP_RUN: begin
        if (!stat_i.cnt_zero) cmd_o = CMD_DIV_STEP;
      end
      ST_DIVM_END: cmd_o = stat_i.rem_zero ? CMD_TAKE_M : CMD_DIV_R;
      ST_DIVR_END: if (stat_i.rem_zero) cmd_o = CMD_TAKE_R;
      ST_MUL_GO:   cmd_o = CMD_MUL;
      ST_MUL_RUN:  if (!stat_i.cnt_zero) cmd_o = CMD_MUL_STEP;
      ST_MUL_END: begin
        priority if (!stat_i.rem_zero) cmd_o = CMD_FIN_OVF;
        else if (stat_i.early)         cmd_o = CMD_TAKE_P_NEXT;
        else                           cmd_o = CMD_DIV_P;
      end
      ST_DIVP_END: cmd_o = CMD_TAKE_Q_NEXT;
      ST_OUT:      out_valid_o = 1'b1;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ===== design/binomial_coefficient_unit_core.sv =====
// Top level of the binomial coefficient unit: controller plus datapath.
// Depends on bcu_pkg, bcu_ctrl, bcu_datapath and the assertion macro header.
//
// channel | signals                         | handshake
// input   | n_value_i, k_value_i            | in_valid_i / in_ready_o
// output  | coefficient_o, overflow_o       | out_valid_o / out_ready_i
//
// One item at a time. Each multiplicative step d runs, in order: a restoring
// division of m, a second one of r when that fails, a shift-add multiply and
// then, if neither division succeeded, a trailing division, all on the one
// shared unit. Steps run until completion or overflow.
// Reset (asynchronous, active low) returns the controller to idle.
// The result is held until taken; a new item is accepted after that.
`default_nettype none
`include "binomial_coefficient_unit_core_macros.svh"
module binomial_coefficient_unit_core #(
  parameter int unsigned WIDTH = bcu_pkg::DEF_WIDTH
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [bcu_pkg::FIELD_W-1:0] n_value_i,
  input  wire logic [bcu_pkg::FIELD_W-1:0] k_value_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [bcu_pkg::FIELD_W-1:0]      coefficient_o,
  output logic                             overflow_o
);
  import bcu_pkg::*;

  cmd_e             cmd;
  stat_t            stat;
  logic [WIDTH-1:0] coef;

  bcu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bcu_datapath #(.WIDTH(WIDTH)) u_dp (
    .clk_i     (clk_i),
    .cmd_i     (cmd),
    .n_value_i (n_value_i),
    .k_value_i (k_value_i),
    .stat_o    (stat),
    .coef_o    (coef),
    .ovf_o     (overflow_o)
  );

  // Zero-extend to the port width
  assign coefficient_o = FIELD_W'(coef);

  `BCU_ASSERT_IMP(a_ovf_zero, out_valid_o && overflow_o, coefficient_o == '0)
  `BCU_ASSERT_NXT(a_no_instant_result, in_valid_i && in_ready_o, !out_valid_o)
  `BCU_ASSERT_IMP(a_one_at_a_time, out_valid_o, !in_ready_o)
endmodule
`default_nettype wire

// ===== dv/tb_binomial_coefficient_unit_core.sv =====
// Testbench for binomial_coefficient_unit_core: directed table plus random n/k pairs;
// typed rows are checked against table values, the rest against an in-bench model
// of the multiplicative C(n,k) algorithm. Depends on bcu_pkg and the RTL of the unit.
`timescale 1ns / 1ps
module tb_binomial_coefficient_unit_core;
  import bcu_pkg::*;

  localparam longint unsigned ALL1     = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int              N_RANDOM = 1030;
  localparam int              CALM_AT  = 900;
  localparam int              WD_LIMIT = 60000;

  typedef struct {
    logic [FIELD_W-1:0] n;
    logic [FIELD_W-1:0] k;
    bit                 typed;
    logic [FIELD_W-1:0] coef;
    logic               ovf;
  } choose_row_t;

  typedef struct {
    logic [FIELD_W-1:0] coef;
    logic               ovf;
  } choose_res_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [FIELD_W-1:0] n_value_i;
  logic [FIELD_W-1:0] k_value_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [FIELD_W-1:0] coefficient_o;
  logic               overflow_o;

  choose_row_t pair_tab[$];
  choose_row_t pending_row;
  choose_res_t coef_q[$];
  int          mismatches;
  int          taken;
  int          sent;
  int          idle_cycles;
  bit          calm;
  bit          stim_done;

  binomial_coefficient_unit_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .n_value_i(n_value_i), .k_value_i(k_value_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .coefficient_o(coefficient_o), .overflow_o(overflow_o)
  );

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // Append one row to the stimulus table
  function automatic void add_row(input choose_row_t row);
    pair_tab = {pair_tab, row};
  endfunction

  // Multiplicative C(n,k); stop with overflow at the first product that wraps
  function automatic choose_res_t binom(input longint unsigned n, input longint unsigned k);
    choose_res_t     res;
    longint unsigned r;
    longint unsigned m;
    longint unsigned d;
    bit              early;
    res.coef = '0;
    res.ovf  = 1'b0;
    r = 1;
    if (k > n) return res;
    if (n - k < k) k = n - k;
    for (d = 1; d <= k; d++) begin
      m = n - (d - 1);
      early = 1'b1;
      if (m % d == 0) m = m / d;
      else if (r % d == 0) r = r / d;
      else early = 1'b0;
      if (r > ALL1 / m) begin
        res.ovf = 1'b1;
        return res;
      end
      r = r * m;
      if (!early) r = r / d;
    end
    res.coef = r;
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic choose_row_t mk(input logic [63:0] n, input logic [63:0] k, input bit typed,
                                     input logic [63:0] coef, input logic ovf);
    choose_row_t row;
    row.n = n; row.k = k; row.typed = typed; row.coef = coef; row.ovf = ovf;
    return row;
  endfunction

  // Random pair, biased toward cases that finish without running many steps
  function automatic choose_row_t rand_pair();
    logic [63:0] n;
    logic [63:0] k;
    int          sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      n = $urandom_range(0, 70);
      k = $urandom_range(0, n + 2);
    end else if (sel < 7) begin
      n = rand64();
      k = $urandom_range(0, 3);
      if ($urandom_range(0, 1)) k = n - k;
    end else if (sel < 9) begin
      n = rand64();
      k = rand64();
    end else begin
      n = $urandom_range(0, 300);
      k = $urandom_range(0, 6);
    end
    return mk(n, k, 1'b0, '0, 1'b0);
  endfunction

  // Accept transactions on both sides and check results in order
  always @(posedge clk_i) begin
    choose_res_t exp_res;
    choose_res_t got;
    if (in_valid_i && in_ready_o) begin
      if (pending_row.typed) begin
        exp_res.coef = pending_row.coef;
        exp_res.ovf  = pending_row.ovf;
      end else begin
        exp_res = binom(pending_row.n, pending_row.k);
      end
      coef_q = {coef_q, exp_res};
    end
    if (out_valid_o && out_ready_i) begin
      taken++;
      if (coef_q.size() == 0) begin
        $error("result without pending expectation: coefficient %h overflow %b",
               coefficient_o, overflow_o);
        mismatches++;
      end else begin
        got = coef_q.pop_front();
        if (coefficient_o !== got.coef) begin
          $error("coefficient: expected %h actual %h", got.coef, coefficient_o);
          mismatches++;
        end
        if (overflow_o !== got.ovf) begin
          $error("overflow: expected %b actual %b", got.ovf, overflow_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: count cycles with no transaction on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold-off, none near the end
  initial begin
    bit held;
    held = 1'b0;
    out_ready_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && taken >= 30) begin
        held = 1'b1;
        out_ready_i = 1'b0;
        repeat (400) @(negedge clk_i);
      end
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(1, 8) - 1) @(negedge clk_i);
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  // Sender and end of run
  initial begin
    int i;
    mismatches  = 0;
    taken       = 0;
    sent        = 0;
    idle_cycles = 0;
    calm        = 1'b0;
    stim_done   = 1'b0;
    in_valid_i  = 1'b0;
    n_value_i   = '0;
    k_value_i   = '0;
    pending_row = mk('0, '0, 1'b0, '0, 1'b0);
    rst_ni      = 1'b0;

    // Directed rows: extremes, k > n, k = 0, k = n, overflow and deep loops
    add_row(mk(0, 0, 1, 1, 0));
    add_row(mk(5, 0, 1, 1, 0));
    add_row(mk(5, 5, 1, 1, 0));
    add_row(mk(1, 1, 1, 1, 0));
    add_row(mk(3, 7, 1, 0, 0));
    add_row(mk(0, ALL1, 1, 0, 0));
    add_row(mk(ALL1 - 1, ALL1, 1, 0, 0));
    add_row(mk(ALL1, ALL1, 1, 1, 0));
    add_row(mk(ALL1, 0, 1, 1, 0));
    add_row(mk(ALL1, 1, 1, ALL1, 0));
    add_row(mk(ALL1, ALL1 - 1, 1, ALL1, 0));
    add_row(mk(ALL1, 2, 1, 0, 1));
    add_row(mk(10, 3, 1, 120, 0));
    add_row(mk(20, 10, 1, 184756, 0));
    add_row(mk(62, 31, 0, 0, 0));
    add_row(mk(66, 33, 0, 0, 0));
    add_row(mk(67, 33, 0, 0, 0));
    add_row(mk(68, 34, 0, 0, 0));
    add_row(mk(100, 50, 0, 0, 0));
    add_row(mk(64'h8000_0000_0000_0000, 3, 0, 0, 0));
    add_row(mk(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1, 0, 0));
    for (i = 0; i < N_RANDOM; i++) add_row(rand_pair());

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (pair_tab[j]) begin
      if (j >= CALM_AT) calm = 1'b1;
      // Drop valid for a burst now and then
      if (!calm && j > 25 && $urandom_range(0, 5) == 0) begin
        in_valid_i = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
      end
      pending_row = pair_tab[j];
      n_value_i   = pair_tab[j].n;
      k_value_i   = pair_tab[j].k;
      in_valid_i  = 1'b1;
      do @(posedge clk_i); while (!in_ready_o);
      sent++;
      @(negedge clk_i);
    end
    in_valid_i = 1'b0;
    stim_done  = 1'b1;

    // Drain, then allow a few cycles for stray results
    while (coef_q.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (mismatches == 0 && coef_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
